FILE: rtl/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types and codes for the ray/sphere nearest-hit unit.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam int MaxSpheres = 16;
  localparam int FracBits   = 16;
  localparam int IdxW       = $clog2(MaxSpheres);
  localparam int CntW       = IdxW + 1;

  // datapath operation codes
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_WRITE  = 4'd1;
  localparam logic [3:0] OP_QLOAD  = 4'd2;
  localparam logic [3:0] OP_READ   = 4'd3;
  localparam logic [3:0] OP_DIFF   = 4'd4;
  localparam logic [3:0] OP_MUL    = 4'd5;
  localparam logic [3:0] OP_ACC    = 4'd6;
  localparam logic [3:0] OP_CMP    = 4'd7;
  localparam logic [3:0] OP_SQINIT = 4'd8;
  localparam logic [3:0] OP_SQSTEP = 4'd9;
  localparam logic [3:0] OP_UPDATE = 4'd10;

  // multiplier operand selects
  localparam logic [2:0] SEL_DOT_X = 3'd0;
  localparam logic [2:0] SEL_DOT_Y = 3'd1;
  localparam logic [2:0] SEL_DOT_Z = 3'd2;
  localparam logic [2:0] SEL_SQ_X  = 3'd3;
  localparam logic [2:0] SEL_SQ_Y  = 3'd4;
  localparam logic [2:0] SEL_SQ_Z  = 3'd5;
  localparam logic [2:0] SEL_SQ_R  = 3'd6;
  localparam logic [2:0] SEL_SQ_S  = 3'd7;

  typedef struct packed {
    logic               op;
    logic [IdxW-1:0]    slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic [CntW-1:0]    skip_entry;
  } req_word_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      sel;
    logic [CntW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_entry;
    logic [31:0]     hit_distance;
  } rsp_word_t;

endpackage

FILE: rtl/rsnh_if.sv
// ----------------------------------------------------------------------------
// rsnh_req_if / rsnh_rsp_if
// Valid/ready channels for query and write words and for result words.
// ----------------------------------------------------------------------------
interface rsnh_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        radius;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;
  logic [4:0]         skip_entry;
  modport source (output valid, op, slot, pos_x, pos_y, pos_z, radius,
                  dir_x, dir_y, dir_z, skip_entry, input ready);
  modport sink   (input valid, op, slot, pos_x, pos_y, pos_z, radius,
                  dir_x, dir_y, dir_z, skip_entry, output ready);
endinterface

interface rsnh_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  hit_entry;
  logic [31:0] hit_distance;
  modport source (output valid, hit, hit_entry, hit_distance, input ready);
  modport sink   (input valid, hit, hit_entry, hit_distance, output ready);
endinterface

FILE: rtl/rsnh_ctrl.sv
// ----------------------------------------------------------------------------
// rsnh_ctrl
// Sequencer: walks the table one sphere at a time and drives the datapath.
// ----------------------------------------------------------------------------
module rsnh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [rsnh_pkg::CntW-1:0] cfg_data,
  input  logic                   req_valid,
  input  logic                   req_op,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsnh_pkg::dp_cmd_t      cmd
);
  import rsnh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SQI  = 4'd6;
  localparam logic [3:0] S_SQS  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]      state, state_next;
  logic [CntW-1:0] sphere_count;
  logic [CntW-1:0] idx, idx_next;
  logic [2:0]      sel, sel_next;
  logic [4:0]      step, step_next;
  logic [CntW-1:0] n_used;

  assign n_used = (sphere_count > CntW'(MaxSpheres)) ? CntW'(MaxSpheres) : sphere_count;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sphere_count <= '0;
      idx          <= '0;
      sel          <= '0;
      step         <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      sel   <= sel_next;
      step  <= step_next;
      if (cfg_we) begin
        sphere_count <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    sel_next   = sel;
    step_next  = step;
    cmd.op     = OP_NONE;
    cmd.sel    = sel;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (!req_op) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op     = OP_QLOAD;
            idx_next   = '0;
            state_next = (n_used == '0) ? S_OUT : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        sel_next   = SEL_DOT_X;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (sel == SEL_SQ_S) begin
          state_next = S_CMP;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = S_MUL;
        end
      end
      S_CMP: begin
        cmd.op     = OP_CMP;
        state_next = S_SQI;
      end
      S_SQI: begin
        cmd.op     = OP_SQINIT;
        step_next  = '0;
        state_next = S_SQS;
      end
      S_SQS: begin
        cmd.op    = OP_SQSTEP;
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        if (idx == n_used - CntW'(1)) begin
          state_next = S_OUT;
        end else begin
          idx_next   = idx + CntW'(1);
          state_next = S_READ;
        end
      end
      S_OUT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rsnh_dp.sv
// ----------------------------------------------------------------------------
// rsnh_dp
// Datapath: sphere table, shared multiplier, accumulators, bitwise square
// root and nearest-hit tracking.
// ----------------------------------------------------------------------------
module rsnh_dp (
  input  logic                clk,
  input  rsnh_pkg::dp_cmd_t   cmd,
  input  rsnh_pkg::req_word_t req_word,
  output rsnh_pkg::rsp_word_t rsp_word
);
  import rsnh_pkg::*;

  logic [126:0] mem [MaxSpheres];
  logic [126:0] rd;

  logic signed [31:0] ox, oy, oz;
  logic signed [17:0] dx, dy, dz;
  logic [CntW-1:0]    skip;
  logic signed [32:0] ex, ey, ez;
  logic [30:0]        r;
  logic signed [36:0] ma, mb;
  logic signed [73:0] prod;
  logic signed [53:0] dot;
  logic [67:0]        esq;
  logic [72:0]        rhs;
  logic [72:0]        rad;
  logic               miss;
  logic [63:0]        xr;
  logic [34:0]        rem;
  logic [31:0]        root;
  logic [34:0]        rem_sh, trial;
  logic [35:0]        s;
  logic signed [37:0] span;
  logic               found;
  logic [IdxW-1:0]    best_i;
  logic signed [37:0] best_d;

  function automatic logic [32:0] mag(input logic signed [32:0] v);
    mag = v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign s      = dot[51:16];
  assign rem_sh = {rem[32:0], xr[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign span   = $signed({2'b0, s}) - $signed({6'b0, root});

  always_comb begin
    case (cmd.sel)
      SEL_DOT_X: begin ma = 37'(ex); mb = 37'(dx); end
      SEL_DOT_Y: begin ma = 37'(ey); mb = 37'(dy); end
      SEL_DOT_Z: begin ma = 37'(ez); mb = 37'(dz); end
      SEL_SQ_X:  begin ma = {4'b0, mag(ex)}; mb = {4'b0, mag(ex)}; end
      SEL_SQ_Y:  begin ma = {4'b0, mag(ey)}; mb = {4'b0, mag(ey)}; end
      SEL_SQ_Z:  begin ma = {4'b0, mag(ez)}; mb = {4'b0, mag(ez)}; end
      SEL_SQ_R:  begin ma = {6'b0, r}; mb = {6'b0, r}; end
      default:   begin ma = {1'b0, s}; mb = {1'b0, s}; end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WRITE: begin
        mem[req_word.slot] <= {req_word.pos_x, req_word.pos_y, req_word.pos_z,
                               req_word.radius};
      end
      OP_QLOAD: begin
        ox    <= req_word.pos_x;
        oy    <= req_word.pos_y;
        oz    <= req_word.pos_z;
        dx    <= req_word.dir_x;
        dy    <= req_word.dir_y;
        dz    <= req_word.dir_z;
        skip  <= req_word.skip_entry;
        found <= 1'b0;
      end
      OP_READ: begin
        rd <= mem[cmd.idx[IdxW-1:0]];
      end
      OP_DIFF: begin
        ex <= 33'($signed(rd[126:95])) - 33'(ox);
        ey <= 33'($signed(rd[94:63])) - 33'(oy);
        ez <= 33'($signed(rd[62:31])) - 33'(oz);
        r  <= rd[30:0];
      end
      OP_MUL: begin
        prod <= ma * mb;
      end
      OP_ACC: begin
        case (cmd.sel)
          SEL_DOT_X:                  dot <= prod[53:0];
          SEL_DOT_Y, SEL_DOT_Z:       dot <= dot + prod[53:0];
          SEL_SQ_X:                   esq <= {2'b0, prod[65:0]};
          SEL_SQ_Y, SEL_SQ_Z:         esq <= esq + {2'b0, prod[65:0]};
          SEL_SQ_R:                   rhs <= {1'b0, prod[71:0]};
          default:                    rhs <= rhs + {1'b0, prod[71:0]};
        endcase
      end
      OP_CMP: begin
        miss <= dot[53] || ({5'b0, esq} > rhs);
        rad  <= rhs - {5'b0, esq};
      end
      OP_SQINIT: begin
        xr   <= (rad[72:64] != '0) ? '1 : rad[63:0];
        rem  <= '0;
        root <= '0;
      end
      OP_SQSTEP: begin
        xr <= {xr[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
      end
      OP_UPDATE: begin
        if (!miss && cmd.idx != skip && !span[37] && span != '0 &&
            (!found || span < best_d)) begin
          found  <= 1'b1;
          best_d <= span;
          best_i <= cmd.idx[IdxW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_word.hit = found;
    if (found) begin
      rsp_word.hit_entry    = best_i;
      rsp_word.hit_distance = (best_d[37:32] != '0) ? '1 : best_d[31:0];
    end else begin
      rsp_word.hit_entry    = '0;
      rsp_word.hit_distance = '1;
    end
  end

endmodule

FILE: rtl/ray_sphere_nearest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit_top
// Nearest ray/sphere hit over a 16-entry sphere table, Q16.16.
// ----------------------------------------------------------------------------
//  port     dir  what it carries
//  req      in   write word (center, radius) or query word (ray, skip)
//  rsp      out  hit flag, nearest entry, distance
//  cfg_*    in   sphere_count register
//
//  a write word goes into the table while idle; a query walks the n spheres in use
//  per sphere: one memory read, 8 passes of the shared multiplier, 32 root steps
//  the result is held until taken; no new word is taken meanwhile
//  rst is synchronous; the table holds garbage until written
// ----------------------------------------------------------------------------
module ray_sphere_nearest_hit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  rsnh_req_if.sink    req,
  rsnh_rsp_if.source  rsp
);
  import rsnh_pkg::*;

  dp_cmd_t   cmd;
  req_word_t req_word;
  rsp_word_t rsp_word;

  assign req_word.op         = req.op;
  assign req_word.slot       = req.slot;
  assign req_word.pos_x      = req.pos_x;
  assign req_word.pos_y      = req.pos_y;
  assign req_word.pos_z      = req.pos_z;
  assign req_word.radius     = req.radius;
  assign req_word.dir_x      = req.dir_x;
  assign req_word.dir_y      = req.dir_y;
  assign req_word.dir_z      = req.dir_z;
  assign req_word.skip_entry = req.skip_entry;

  rsnh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rsnh_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .req_word (req_word),
    .rsp_word (rsp_word)
  );

  assign rsp.hit          = rsp_word.hit;
  assign rsp.hit_entry    = rsp_word.hit_entry;
  assign rsp.hit_distance = rsp_word.hit_distance;

endmodule

FILE: rtl/rsnh_checker.sv
// ----------------------------------------------------------------------------
// rsnh_checker
// Port-level checks of the nearest-hit unit, bound to the top level.
// ----------------------------------------------------------------------------
module rsnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_op,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        hit,
  input logic [3:0]  hit_entry,
  input logic [31:0] hit_distance
);

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op |=> !req_ready)
    else $error("ready stayed high after a query word");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_op |=> req_ready && !rsp_valid)
    else $error("write word caused work or a result");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("input open while a result waits");

  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> hit_entry == 4'd0 && hit_distance == 32'hFFFF_FFFF)
    else $error("miss word carries a hit entry or distance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_distance))
    else $error("result dropped or changed while stalled");

endmodule

bind ray_sphere_nearest_hit_top rsnh_checker u_rsnh_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .hit          (rsp.hit),
  .hit_entry    (rsp.hit_entry),
  .hit_distance (rsp.hit_distance)
);

FILE: verif/ray_sphere_nearest_hit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit_top_tb
// Self-checking bench for the ray/sphere nearest-hit unit. Sphere writes and
// ray queries go in on the request channel with random gaps. A local sphere
// table and a Q16.16 tracer predict each result word. Results are checked
// in order as they leave under random backpressure, over several settings
// of the sphere count, extremes included.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_hit_top_tb;
  import rsnh_pkg::*;

  localparam int IdleLimit = 20000;
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;
  localparam logic [4:0] NoSkip = 5'd16;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_data;

  rsnh_req_if req ();
  rsnh_rsp_if rsp ();

  ray_sphere_nearest_hit_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  // local sphere table and count
  logic signed [31:0] ball_x [MaxSpheres];
  logic signed [31:0] ball_y [MaxSpheres];
  logic signed [31:0] ball_z [MaxSpheres];
  logic [30:0]        ball_r [MaxSpheres];
  int unsigned        balls_in_use;

  rsp_word_t hit_queue[$];
  int  err_count;
  int  query_count;
  int  hit_count;
  int  miss_count;
  int  sat_count;
  bit  no_idle;
  int  idle_cycles;
  int  rdy_wait;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [127:0] mag128(input longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    return {64'd0, m};
  endfunction

  function automatic rsp_word_t trace_ray(input req_word_t w);
    rsp_word_t   r;
    longint      ex, ey, ez, dt, span, best;
    logic [127:0] ux, uy, uz, s, rr, esq, rhs, rad;
    logic [63:0] radicand;
    bit          found;
    int unsigned n;
    n = (balls_in_use > MaxSpheres) ? MaxSpheres : balls_in_use;
    found = 0;
    best = 0;
    r.hit = 0;
    r.hit_entry = '0;
    r.hit_distance = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      if (i == int'(w.skip_entry)) continue;
      ex = longint'(ball_x[i]) - longint'(w.pos_x);
      ey = longint'(ball_y[i]) - longint'(w.pos_y);
      ez = longint'(ball_z[i]) - longint'(w.pos_z);
      dt = ex * longint'(w.dir_x) + ey * longint'(w.dir_y) + ez * longint'(w.dir_z);
      if (dt < 0) continue;
      s = {64'd0, 64'(dt >>> FracBits)};
      ux = mag128(ex);
      uy = mag128(ey);
      uz = mag128(ez);
      esq = ux * ux + uy * uy + uz * uz;
      rr = {97'd0, ball_r[i]};
      rhs = s * s + rr * rr;
      if (esq > rhs) continue;
      rad = rhs - esq;
      radicand = (rad[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rad[63:0];
      span = longint'(s[63:0]) - longint'(floor_sqrt(radicand));
      if (span > 0 && (!found || span < best)) begin
        found = 1;
        best = span;
        r.hit_entry = i[IdxW-1:0];
      end
    end
    if (found) begin
      r.hit = 1;
      r.hit_distance = (best > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
    end
    return r;
  endfunction

  task automatic send_word(input req_word_t w);
    int gap;
    req.valid      <= 1'b1;
    req.op         <= w.op;
    req.slot       <= w.slot;
    req.pos_x      <= w.pos_x;
    req.pos_y      <= w.pos_y;
    req.pos_z      <= w.pos_z;
    req.radius     <= w.radius;
    req.dir_x      <= w.dir_x;
    req.dir_y      <= w.dir_y;
    req.dir_z      <= w.dir_z;
    req.skip_entry <= w.skip_entry;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (w.op == OpWrite) begin
      ball_x[w.slot] = w.pos_x;
      ball_y[w.slot] = w.pos_y;
      ball_z[w.slot] = w.pos_z;
      ball_r[w.slot] = w.radius;
    end else begin
      hit_queue.insert(hit_queue.size(), trace_ray(w));
      query_count++;
    end
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= n[4:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    balls_in_use = n;
  endtask

  function automatic req_word_t ball_word(input int slot, input int x, input int y,
                                          input int z, input int r);
    req_word_t w;
    w.op = OpWrite;
    w.slot = slot[3:0];
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.radius = r[30:0];
    w.dir_x = 18'($urandom);
    w.dir_y = 18'($urandom);
    w.dir_z = 18'($urandom);
    w.skip_entry = 5'($urandom_range(0, 16));
    return w;
  endfunction

  function automatic req_word_t ray_word(input int x, input int y, input int z,
                                         input int dx, input int dy, input int dz,
                                         input int skip);
    req_word_t w;
    w.op = OpQuery;
    w.slot = 4'($urandom);
    w.radius = 31'($urandom);
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.dir_x = 18'(dx);
    w.dir_y = 18'(dy);
    w.dir_z = 18'(dz);
    w.skip_entry = skip[4:0];
    return w;
  endfunction

  // normalized ray from origin toward a point, units of 1.0
  function automatic req_word_t aimed_ray(input real ox, input real oy, input real oz,
                                          input real tx, input real ty, input real tz,
                                          input int skip);
    real vx, vy, vz, len;
    vx = tx - ox;
    vy = ty - oy;
    vz = tz - oz;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0e-6) begin
      vx = 1.0;
      len = 1.0;
    end
    return ray_word($rtoi(ox * 65536.0), $rtoi(oy * 65536.0), $rtoi(oz * 65536.0),
                    $rtoi(vx / len * 65536.0), $rtoi(vy / len * 65536.0),
                    $rtoi(vz / len * 65536.0), skip);
  endfunction

  function automatic real rnd_unit(input int span);
    return (real'($urandom_range(0, 2 * span * 256)) / 256.0) - real'(span);
  endfunction

  function automatic req_word_t noise_word();
    req_word_t w;
    w.op = 1'($urandom);
    w.slot = 4'($urandom);
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.radius = 31'($urandom);
    w.dir_x = 18'($urandom_range(0, 131072) - 65536);
    w.dir_y = 18'($urandom_range(0, 131072) - 65536);
    w.dir_z = 18'($urandom_range(0, 131072) - 65536);
    w.skip_entry = 5'($urandom_range(0, 16));
    return w;
  endfunction

  // result side: random stall per word, in-order check, idle watchdog
  always @(posedge clk) begin
    rsp_word_t e;
    int w;
    if (rst) begin
      rsp.ready <= 1'b0;
      rdy_wait = 0;
      idle_cycles = 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no word moved in %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (rsp.valid && rsp.ready) begin
        if (hit_queue.size() == 0) begin
          $error("result word with none expected");
          err_count++;
        end else begin
          e = hit_queue.pop_front();
          if (rsp.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, rsp.hit);
            err_count++;
          end
          if (rsp.hit_entry !== e.hit_entry) begin
            $error("hit_entry: expected %0d, got %0d", e.hit_entry, rsp.hit_entry);
            err_count++;
          end
          if (rsp.hit_distance !== e.hit_distance) begin
            $error("hit_distance: expected %h, got %h", e.hit_distance, rsp.hit_distance);
            err_count++;
          end
          if (e.hit) hit_count++;
          else miss_count++;
          if (e.hit && e.hit_distance == 32'hFFFF_FFFF) sat_count++;
        end
        w = draw_gap();
        rdy_wait = w;
        rsp.ready <= (w == 0);
      end else if (!rsp.ready) begin
        if (rdy_wait <= 1) rsp.ready <= 1'b1;
        rdy_wait--;
      end
    end
  end

  // empty table: every query misses
  task automatic test_empty_table();
    send_word(ray_word(0, 0, 0, 65536, 0, 0, NoSkip));
    send_word(ray_word(-1, 32'h7FFF_FFFF, 0, 0, -65536, 0, 0));
  endtask

  // fill every entry so later reads never see an unwritten one
  task automatic test_fill_table();
    for (int i = 0; i < MaxSpheres; i++)
      send_word(ball_word(i, (i + 1) * 8 * 65536, 0, 0, 65536));
    set_count(MaxSpheres);
  endtask

  task automatic test_directed();
    // axis rays, front and behind
    send_word(ray_word(0, 0, 0, 65536, 0, 0, NoSkip));
    send_word(ray_word(0, 0, 0, -65536, 0, 0, NoSkip));
    // skip of the nearest entry and of the last entry
    send_word(ray_word(0, 0, 0, 65536, 0, 0, 0));
    send_word(ray_word(0, 0, 0, 65536, 0, 0, 15));
    // origin inside a sphere, tangent ray
    send_word(ray_word(8 * 65536, 0, 0, 65536, 0, 0, NoSkip));
    send_word(ray_word(0, 65536, 0, 65536, 0, 0, NoSkip));
    // tie: twin of entry 0 in entry 1
    send_word(ball_word(1, 8 * 65536, 0, 0, 65536));
    send_word(ray_word(0, 0, 0, 65536, 0, 0, NoSkip));
    // far sphere near the top of the range, rays from the far negative end
    send_word(ball_word(2, 32'h7FFF_0000, 0, 0, 65536));
    send_word(ray_word(32'h8000_0000, 0, 0, 65536, 0, 0, 0));
    send_word(ray_word(32'h8000_0000, 0, 0, 65536, 0, 0, 1));
    // non-unit direction and extreme fields: wide radicand saturates
    send_word(ball_word(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(ray_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       65536, 65536, 65536, 0));
    send_word(ray_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       -65536, -65536, -65536, NoSkip));
    send_word(ball_word(4, 0, 0, 0, 0));
    send_word(ray_word(-65536, 0, 0, 65536, 0, 0, 0));
    // fewer entries in use
    set_count(1);
    send_word(ray_word(0, 0, 0, 65536, 0, 0, NoSkip));
    send_word(ray_word(0, 0, 0, 65536, 0, 0, 0));
  endtask

  task automatic test_random_scenes(input int n_items);
    int cnt;
    int tgt;
    for (int p = 0; p < 6; p++) begin
      no_idle = (p == 2);
      cnt = (p == 0) ? MaxSpheres : (p == 3) ? 0 : $urandom_range(1, MaxSpheres);
      drain();
      for (int i = 0; i < MaxSpheres; i++)
        send_word(ball_word(i, $rtoi(rnd_unit(32) * 65536.0), $rtoi(rnd_unit(32) * 65536.0),
                            $rtoi(rnd_unit(32) * 65536.0), $urandom_range(1, 8 * 65536)));
      set_count(cnt);
      for (int k = 0; k < n_items / 6; k++) begin
        tgt = $urandom_range(0, MaxSpheres - 1);
        case ($urandom_range(0, 9))
          0: send_word(noise_word());
          1: send_word(ball_word($urandom_range(0, MaxSpheres - 1),
                                 $rtoi(rnd_unit(32) * 65536.0), $rtoi(rnd_unit(32) * 65536.0),
                                 $rtoi(rnd_unit(32) * 65536.0), $urandom_range(0, 8 * 65536)));
          default: send_word(aimed_ray(rnd_unit(48), rnd_unit(48), rnd_unit(48),
                                       real'(ball_x[tgt]) / 65536.0 + rnd_unit(2),
                                       real'(ball_y[tgt]) / 65536.0 + rnd_unit(2),
                                       real'(ball_z[tgt]) / 65536.0 + rnd_unit(2),
                                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
                                                                    : NoSkip));
        endcase
      end
    end
    no_idle = 0;
  endtask

  initial begin
    err_count = 0;
    query_count = 0;
    hit_count = 0;
    miss_count = 0;
    sat_count = 0;
    no_idle = 0;
    balls_in_use = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.op <= OpQuery;
    req.slot <= '0;
    req.pos_x <= '0;
    req.pos_y <= '0;
    req.pos_z <= '0;
    req.radius <= '0;
    req.dir_x <= '0;
    req.dir_y <= '0;
    req.dir_z <= '0;
    req.skip_entry <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_directed();
    test_random_scenes(1500);
    set_count(MaxSpheres);
    drain();
    repeat (900) @(posedge clk);

    $display("%0d queries checked: %0d hits (%0d saturated), %0d misses",
             query_count, hit_count, sat_count, miss_count);
    $display("sphere counts 0, 1, 16 and random; random gaps and result stalls");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rsnh_pkg.sv
rtl/rsnh_if.sv
rtl/rsnh_ctrl.sv
rtl/rsnh_dp.sv
rtl/ray_sphere_nearest_hit_top.sv
rtl/rsnh_checker.sv
verif/ray_sphere_nearest_hit_top_tb.sv
